### hdl/scpa_pkg.sv
// shared types, codes and constants of the size class pool allocator
package scpa_pkg;

  // default sizing of the top level
  localparam int NUM_SHELVES_DEF      = 4;
  localparam int CHUNKS_PER_SHELF_DEF = 64;
  localparam int SIZE_BITS_DEF        = 16;

  // fixed field widths
  localparam int REQ_W      = 16;
  localparam int CNT_W      = 7;
  localparam int CTR_W      = 32;
  localparam int HEAD_MAX_W = 10;
  localparam int CLS_MAX_W  = 3;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 16;

  // register map
  localparam logic [CFG_AW-1:0] REG_SIZE_FIRST  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_COUNT_FIRST = 3'd4;
  localparam int                REG_CLASSES     = 4;

  // reset values of the class registers and the free count saturation value
  localparam int               RST_SIZE_BASE = 16;
  localparam logic [CNT_W-1:0] RST_COUNT     = 7'd64;
  localparam logic [CNT_W-1:0] FREE_SAT      = 7'd127;

  // item functions
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STAT,
    ST_LINK
  } state_t;

  // per-class record held in the class memory
  typedef struct packed {
    logic [HEAD_MAX_W-1:0] head;
    logic [CNT_W-1:0]      free_left;
    logic [CNT_W-1:0]      low_water;
    logic [CTR_W-1:0]      allocs;
    logic [CTR_W-1:0]      frees;
    logic [CTR_W-1:0]      fails;
  } stats_t;

  // first fit result
  typedef struct packed {
    logic                 found;
    logic [CLS_MAX_W-1:0] cls;
  } fit_t;

  // class reinit request from a count register write
  typedef struct packed {
    logic                 valid;
    logic [CLS_MAX_W-1:0] cls;
  } reinit_t;

  // one result word
  typedef struct packed {
    logic [1:0]       status;
    logic [1:0]       grant_shelf;
    logic [5:0]       grant_chunk;
    logic [CNT_W-1:0] chunks_left;
    logic [CNT_W-1:0] peak_in_use;
    logic [CTR_W-1:0] alloc_total;
    logic [CTR_W-1:0] free_total;
    logic [CTR_W-1:0] fail_total;
    logic [REQ_W-1:0] largest_request;
    logic             counts_mismatch;
  } result_t;

endpackage

### hdl/size_class_pool_allocator.sv
// top level of the size class pool allocator
//
// pool allocator with NUM_SHELVES size classes of up to CHUNKS_PER_SHELF chunks
// each; every class keeps a lifo free list of chunk indices. one item is in work
// at a time: a free, a query, a refused allocate or an exhausted allocate
// reads its class record and then loads its result word; a granted allocate
// also reads the link memory before its word is loaded, because the class
// record read from the class memory gives the list head, which then
// addresses the link memory. both memories have a registered read.
// a pending result sits in an output register, so the next item is accepted
// while it waits; the following result waits until the register is taken.
// configuration writes are always accepted and take effect at once; a write to
// a count register reinitializes its class through valid bits (one per class
// record, one per link entry) so no clearing pass is needed after reset or
// reinit.
module size_class_pool_allocator import scpa_pkg::*; #(
  parameter int NUM_SHELVES      = NUM_SHELVES_DEF,
  parameter int CHUNKS_PER_SHELF = CHUNKS_PER_SHELF_DEF,
  parameter int SIZE_BITS        = SIZE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [REQ_W-1:0]  in_request_size,
  input  logic [1:0]        in_handle_shelf,
  input  logic [5:0]        in_handle_chunk,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [1:0]        out_grant_shelf,
  output logic [5:0]        out_grant_chunk,
  output logic [CNT_W-1:0]  out_chunks_left,
  output logic [CNT_W-1:0]  out_peak_in_use,
  output logic [CTR_W-1:0]  out_alloc_total,
  output logic [CTR_W-1:0]  out_free_total,
  output logic [CTR_W-1:0]  out_fail_total,
  output logic [REQ_W-1:0]  out_largest_request,
  output logic              out_counts_mismatch,
  // configuration words
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int SHELF_W    = (NUM_SHELVES > 1) ? $clog2(NUM_SHELVES) : 1;
  localparam int CHUNK_W    = (CHUNKS_PER_SHELF > 1) ? $clog2(CHUNKS_PER_SHELF) : 1;
  localparam int LINK_DEPTH = NUM_SHELVES << CHUNK_W;
  localparam int LINK_AW    = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam logic [REQ_W-1:0] REQ_MASK =
    (SIZE_BITS >= REQ_W) ? '1 : REQ_W'((33'd1 << SIZE_BITS) - 33'd1);

  // control state
  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;
  logic   accept;

  // captured item
  logic [1:0]           func_r;
  logic                 found_r;
  logic [SHELF_W-1:0]   cls_r;
  logic                 hs_ok_r;
  logic [5:0]           hc_r;
  logic [REQ_W-1:0]     largest_r;

  // valid bits; a clear bit reads as the initial value
  logic [NUM_SHELVES-1:0] stat_vld_r;
  logic [LINK_DEPTH-1:0]  link_vld_r;
  logic                   stat_vld_rd_r;
  logic                   link_vld_rd_r;
  logic [CHUNK_W-1:0]     link_def_r;

  // register block
  fit_t             fit;
  reinit_t          reinit;
  logic [CNT_W-1:0] eff;
  logic [REQ_W-1:0] req_m;

  // class memory
  logic               stat_re, stat_we;
  logic [SHELF_W-1:0] stat_raddr;
  stats_t             stat_wdata, stat_rdata, cur;

  // link memory
  logic               link_re, link_we;
  logic [LINK_AW-1:0] link_raddr, link_waddr;
  logic [CHUNK_W-1:0] link_wdata, link_rdata, link_val;

  // misc datapath
  logic [CLS_MAX_W-1:0] cls_in;
  logic [15:0]          hc_wide;
  logic [CHUNK_W-1:0]   hc_idx;
  logic [CHUNK_W-1:0]   cur_head;
  logic                 hc_ok;
  logic [CNT_W-1:0]     fl_dec;
  logic [3:0]           cls_wide;
  logic [15:0]          head_wide;
  logic [15:0]          link_def_wide;
  result_t              res_nxt, res_r;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign req_m     = in_request_size & REQ_MASK;

  scpa_regs #(
    .NUM_SHELVES     (NUM_SHELVES),
    .CHUNKS_PER_SHELF(CHUNKS_PER_SHELF),
    .SIZE_BITS       (SIZE_BITS)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_m),
    .sel_cls  (cls_r),
    .fit      (fit),
    .eff_count(eff),
    .reinit   (reinit)
  );

  scpa_ram #(
    .WIDTH($bits(stats_t)),
    .DEPTH(NUM_SHELVES)
  ) u_stat_ram (
    .clk  (clk),
    .we   (stat_we),
    .waddr(cls_r),
    .wdata(stat_wdata),
    .re   (stat_re),
    .raddr(stat_raddr),
    .rdata(stat_rdata)
  );

  scpa_ram #(
    .WIDTH(CHUNK_W),
    .DEPTH(LINK_DEPTH)
  ) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .re   (link_re),
    .raddr(link_raddr),
    .rdata(link_rdata)
  );

  // class of the item: first fit for an allocate, the handle otherwise
  assign cls_in = (in_func == FUNC_ALLOC) ? fit.cls : {1'b0, in_handle_shelf};

  // class record as seen by this item
  always_comb begin
    if (stat_vld_rd_r) begin
      cur = stat_rdata;
    end else begin
      cur           = '0;
      cur.free_left = eff;
      cur.low_water = eff;
    end
  end

  assign cur_head  = cur.head[CHUNK_W-1:0];
  assign hc_wide   = {10'd0, hc_r};
  assign hc_idx    = hc_wide[CHUNK_W-1:0];
  assign hc_ok     = hs_ok_r && ({1'b0, hc_r} < eff);
  assign link_val  = link_vld_rd_r ? link_rdata : link_def_r;
  assign fl_dec    = cur.free_left - 1'b1;
  assign cls_wide  = 4'(cls_r);
  assign head_wide = 16'(cur_head);
  assign link_def_wide = 16'(cur_head);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_STAT;
        end
      end
      ST_STAT: begin
        if (func_r == FUNC_ALLOC && found_r && cur.free_left != '0) begin
          state_nxt = ST_LINK;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LINK: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory accesses and the result word
  always_comb begin
    stat_re    = 1'b0;
    stat_raddr = cls_in[SHELF_W-1:0];
    stat_we    = 1'b0;
    stat_wdata = cur;
    link_re    = 1'b0;
    link_raddr = LINK_AW'({cls_r, cur_head});
    link_we    = 1'b0;
    link_waddr = LINK_AW'({cls_r, hc_idx});
    link_wdata = cur_head;
    res_nxt    = '0;
    case (state_r)
      ST_IDLE: begin
        stat_re = accept;
      end
      ST_STAT: begin
        case (func_r)
          FUNC_ALLOC: begin
            if (!found_r) begin
              res_nxt.status = STAT_NOFIT;
            end else if (cur.free_left == '0) begin
              // exhausted class counts a failure
              res_nxt.status    = STAT_EMPTY;
              stat_we           = out_free;
              stat_wdata.fails  = cur.fails + 1'b1;
            end else begin
              // fetch the link of the head chunk
              link_re = 1'b1;
            end
          end
          FUNC_FREE: begin
            // push the chunk; a bad handle is dropped silently
            if (hc_ok) begin
              stat_we              = out_free;
              link_we              = out_free;
              stat_wdata.head      = HEAD_MAX_W'(hc_idx);
              stat_wdata.free_left = (cur.free_left < FREE_SAT) ?
                                     cur.free_left + 1'b1 : cur.free_left;
              stat_wdata.frees     = cur.frees + 1'b1;
            end
          end
          FUNC_QUERY: begin
            if (hs_ok_r) begin
              res_nxt.chunks_left     = cur.free_left;
              res_nxt.peak_in_use     = (eff >= cur.low_water) ?
                                        eff - cur.low_water : '0;
              res_nxt.alloc_total     = cur.allocs;
              res_nxt.free_total      = cur.frees;
              res_nxt.fail_total      = cur.fails;
              res_nxt.largest_request = largest_r;
              res_nxt.counts_mismatch = (cur.allocs != cur.frees);
            end
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end
      ST_LINK: begin
        // pop: the link becomes the new head
        stat_we              = out_free;
        stat_wdata.head      = HEAD_MAX_W'(link_val);
        stat_wdata.free_left = fl_dec;
        stat_wdata.low_water = (fl_dec < cur.low_water) ? fl_dec : cur.low_water;
        stat_wdata.allocs    = cur.allocs + 1'b1;
        res_nxt.status       = STAT_OK;
        res_nxt.grant_shelf  = cls_wide[1:0];
        res_nxt.grant_chunk  = head_wide[5:0];
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // result is loaded when the item finishes and the output register is free
  logic out_load;
  assign out_load = out_free &&
                    ((state_r == ST_LINK) ||
                     (state_r == ST_STAT && state_nxt == ST_IDLE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r        <= in_func;
      found_r       <= fit.found;
      cls_r         <= cls_in[SHELF_W-1:0];
      hs_ok_r       <= (32'(in_handle_shelf) < NUM_SHELVES);
      hc_r          <= in_handle_chunk;
      stat_vld_rd_r <= stat_vld_r[cls_in[SHELF_W-1:0]];
    end
    if (link_re) begin
      link_vld_rd_r <= link_vld_r[link_raddr];
      link_def_r    <= (32'(cur_head) == 32'(CHUNKS_PER_SHELF - 1)) ?
                       '0 : link_def_wide[CHUNK_W-1:0] + 1'b1;
    end
  end

  // largest request, failed ones included
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      largest_r <= '0;
    end else if (accept && in_func == FUNC_ALLOC && req_m > largest_r) begin
      largest_r <= req_m;
    end
  end

  // valid bits: cleared by reset or class reinit, set by a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_vld_r <= '0;
      link_vld_r <= '0;
    end else begin
      if (reinit.valid) begin
        for (int s = 0; s < NUM_SHELVES; s++) begin
          if (s == int'(reinit.cls)) begin
            stat_vld_r[s] <= 1'b0;
          end
        end
        for (int i = 0; i < LINK_DEPTH; i++) begin
          if ((i >> CHUNK_W) == int'(reinit.cls)) begin
            link_vld_r[i] <= 1'b0;
          end
        end
      end
      if (stat_we) begin
        stat_vld_r[cls_r] <= 1'b1;
      end
      if (link_we) begin
        link_vld_r[link_waddr] <= 1'b1;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_grant_shelf     = res_r.grant_shelf;
  assign out_grant_chunk     = res_r.grant_chunk;
  assign out_chunks_left     = res_r.chunks_left;
  assign out_peak_in_use     = res_r.peak_in_use;
  assign out_alloc_total     = res_r.alloc_total;
  assign out_free_total      = res_r.free_total;
  assign out_fail_total      = res_r.fail_total;
  assign out_largest_request = res_r.largest_request;
  assign out_counts_mismatch = res_r.counts_mismatch;

endmodule

### hdl/scpa_ram.sv
// generic single write port, single read port ram with registered read
module scpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/scpa_regs.sv
// class size and count registers, first fit selection and effective count
module scpa_regs import scpa_pkg::*; #(
  parameter int NUM_SHELVES      = NUM_SHELVES_DEF,
  parameter int CHUNKS_PER_SHELF = CHUNKS_PER_SHELF_DEF,
  parameter int SIZE_BITS        = SIZE_BITS_DEF,
  localparam int SHELF_W = (NUM_SHELVES > 1) ? $clog2(NUM_SHELVES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [CFG_AW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  input  logic [REQ_W-1:0]   req,
  input  logic [SHELF_W-1:0] sel_cls,
  output fit_t               fit,
  output logic [CNT_W-1:0]   eff_count,
  output reinit_t            reinit
);

  localparam int CMP_W = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

  logic [SIZE_BITS-1:0] size_r  [NUM_SHELVES];
  logic [CNT_W-1:0]     count_r [NUM_SHELVES];
  logic [CFG_AW-1:0]    cnt_slot;
  logic [31:0]          cfg_wide;
  logic [CNT_W-1:0]     cnt_sel;

  function automatic logic [SIZE_BITS-1:0] rst_size(input int s);
    logic [31:0] v;
    begin
      v = 32'(RST_SIZE_BASE) << (2 * s);
      rst_size = (s < REG_CLASSES) ? v[SIZE_BITS-1:0] : '1;
    end
  endfunction

  assign cnt_slot = cfg_index - REG_COUNT_FIRST;
  assign cfg_wide = {16'd0, cfg_data};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SHELVES; s++) begin
        size_r[s]  <= rst_size(s);
        count_r[s] <= (s < REG_CLASSES) ? RST_COUNT : '0;
      end
    end else if (cfg_valid) begin
      for (int s = 0; s < NUM_SHELVES; s++) begin
        if (s < REG_CLASSES) begin
          if (cfg_index < REG_COUNT_FIRST && cfg_index == CFG_AW'(s)) begin
            size_r[s] <= cfg_wide[SIZE_BITS-1:0];
          end
          if (cfg_index >= REG_COUNT_FIRST && cnt_slot == CFG_AW'(s)) begin
            count_r[s] <= cfg_data[CNT_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    reinit.valid = cfg_valid && (cfg_index >= REG_COUNT_FIRST) &&
                   (32'(cnt_slot) < NUM_SHELVES);
    reinit.cls   = CLS_MAX_W'(cnt_slot);
  end

  // lowest class index wins
  always_comb begin
    fit = '0;
    for (int s = NUM_SHELVES - 1; s >= 0; s--) begin
      if (CMP_W'(size_r[s]) >= CMP_W'(req)) begin
        fit.found = 1'b1;
        fit.cls   = CLS_MAX_W'(s);
      end
    end
  end

  assign cnt_sel   = count_r[sel_cls];
  assign eff_count = (32'(cnt_sel) > 32'(CHUNKS_PER_SHELF)) ?
                     CNT_W'(CHUNKS_PER_SHELF) : cnt_sel;

endmodule

### hdl/scpa_checker.sv
// port level assertions of the size class pool allocator and their bind
module scpa_checker import scpa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_func,
  input logic [REQ_W-1:0]  in_request_size,
  input logic [1:0]        in_handle_shelf,
  input logic [5:0]        in_handle_chunk,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic [1:0]        out_grant_shelf,
  input logic [5:0]        out_grant_chunk,
  input logic [CNT_W-1:0]  out_chunks_left,
  input logic [CNT_W-1:0]  out_peak_in_use,
  input logic [CTR_W-1:0]  out_alloc_total,
  input logic [CTR_W-1:0]  out_free_total,
  input logic [CTR_W-1:0]  out_fail_total,
  input logic [REQ_W-1:0]  out_largest_request,
  input logic              out_counts_mismatch,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [CFG_AW-1:0] cfg_index,
  input logic [CFG_DW-1:0] cfg_data
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_grant_chunk) && $stable(out_alloc_total))
    else $error("result word changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // a refused allocate carries no grant and no statistics
  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |->
      out_grant_shelf == '0 && out_grant_chunk == '0 &&
      out_alloc_total == '0 && out_chunks_left == '0)
    else $error("refused allocate carries payload");

  // mismatch flag agrees with the totals
  a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_counts_mismatch == (out_alloc_total != out_free_total))
    else $error("mismatch flag disagrees with totals");

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (.*);

### tb/size_class_pool_allocator_tb.sv
// self-checking testbench of the size class pool allocator, with its own free list predictor
`timescale 1ns / 100ps

module size_class_pool_allocator_tb import scpa_pkg::*;;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NSH         = NUM_SHELVES_DEF;
  localparam int NCH         = CHUNKS_PER_SHELF_DEF;
  localparam int NUM_PHASES  = 8;

  // receiver stall styles
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  // ---------------------------------------------------------------------------
  // scoreboard: free list predictor plus the queue of result words still owed
  // ---------------------------------------------------------------------------
  class pool_scoreboard;
    logic [REQ_W-1:0] shelf_size [NSH];
    logic [CNT_W-1:0] chunk_count [NSH];
    logic [5:0]       next_chunk [NSH][NCH];
    logic [5:0]       head [NSH];
    logic [CNT_W-1:0] free_left [NSH];
    logic [CNT_W-1:0] low_water [NSH];
    logic [CTR_W-1:0] allocs [NSH];
    logic [CTR_W-1:0] frees [NSH];
    logic [CTR_W-1:0] fails [NSH];
    logic [REQ_W-1:0] largest;
    result_t          owed_results [$];
    int mismatches, words_checked;
    int grants, nofits, exhausted, frees_taken, queries;

    function new();
      for (int s = 0; s < NSH; s++) begin
        shelf_size[s]  = REQ_W'(RST_SIZE_BASE << (2 * s));
        chunk_count[s] = RST_COUNT;
        rebuild_class(s);
      end
      largest = '0;
    endfunction

    function logic [CNT_W-1:0] usable(int s);
      return (chunk_count[s] > NCH) ? CNT_W'(NCH) : chunk_count[s];
    endfunction

    function void rebuild_class(int s);
      for (int j = 0; j < NCH; j++) next_chunk[s][j] = 6'((j + 1) % NCH);
      head[s]      = '0;
      free_left[s] = usable(s);
      low_water[s] = usable(s);
      allocs[s]    = '0;
      frees[s]     = '0;
      fails[s]     = '0;
    endfunction

    function void note_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      int s;
      if (idx < REG_COUNT_FIRST) begin
        shelf_size[idx - REG_SIZE_FIRST] = data;
      end else begin
        s = idx - REG_COUNT_FIRST;
        chunk_count[s] = data[CNT_W-1:0];
        rebuild_class(s);
      end
    endfunction

    // works out the result of one accepted word and queues it
    function result_t note_word(logic [1:0] func, logic [REQ_W-1:0] req,
                                logic [1:0] hs, logic [5:0] hc);
      result_t r;
      int s;
      logic [CNT_W-1:0] ec;
      r = '0;
      s = 0;
      case (func)
        FUNC_ALLOC: begin
          if (req > largest) largest = req;
          while (s < NSH && shelf_size[s] < req) s++;
          if (s == NSH) begin
            r.status = STAT_NOFIT;
            nofits++;
          end else if (free_left[s] == 0) begin
            r.status = STAT_EMPTY;
            fails[s] += 1;
            exhausted++;
          end else begin
            r.status      = STAT_OK;
            r.grant_shelf = 2'(s);
            r.grant_chunk = head[s];
            head[s]       = next_chunk[s][head[s]];
            free_left[s]  = free_left[s] - 1'b1;
            if (free_left[s] < low_water[s]) low_water[s] = free_left[s];
            allocs[s] += 1;
            grants++;
          end
        end
        FUNC_FREE: begin
          if (hs < NSH && hc < usable(hs)) begin
            next_chunk[hs][hc] = head[hs];
            head[hs] = hc;
            if (free_left[hs] < FREE_SAT) free_left[hs] = free_left[hs] + 1'b1;
            frees[hs] += 1;
            frees_taken++;
          end
        end
        FUNC_QUERY: begin
          queries++;
          if (hs < NSH) begin
            ec = usable(hs);
            r.chunks_left     = free_left[hs];
            r.peak_in_use     = (ec >= low_water[hs]) ? ec - low_water[hs] : '0;
            r.alloc_total     = allocs[hs];
            r.free_total      = frees[hs];
            r.fail_total      = fails[hs];
            r.largest_request = largest;
            r.counts_mismatch = (allocs[hs] != frees[hs]);
          end
        end
        default: ;
      endcase
      owed_results.push_back(r);
      return r;
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("word %0d: %s expected 0x%0h, got 0x%0h", words_checked, field, want, got);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing owed: 0x%0h", got);
        return;
      end
      want = owed_results.pop_front();
      if (got.status != want.status) flag("status", want.status, got.status);
      if (got.grant_shelf != want.grant_shelf)
        flag("grant_shelf", want.grant_shelf, got.grant_shelf);
      if (got.grant_chunk != want.grant_chunk)
        flag("grant_chunk", want.grant_chunk, got.grant_chunk);
      if (got.chunks_left != want.chunks_left)
        flag("chunks_left", want.chunks_left, got.chunks_left);
      if (got.peak_in_use != want.peak_in_use)
        flag("peak_in_use", want.peak_in_use, got.peak_in_use);
      if (got.alloc_total != want.alloc_total)
        flag("alloc_total", want.alloc_total, got.alloc_total);
      if (got.free_total != want.free_total)
        flag("free_total", want.free_total, got.free_total);
      if (got.fail_total != want.fail_total)
        flag("fail_total", want.fail_total, got.fail_total);
      if (got.largest_request != want.largest_request)
        flag("largest_request", want.largest_request, got.largest_request);
      if (got.counts_mismatch != want.counts_mismatch)
        flag("counts_mismatch", want.counts_mismatch, got.counts_mismatch);
      words_checked++;
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_func = FUNC_QUERY;
  logic [REQ_W-1:0]  in_request_size = '0;
  logic [1:0]        in_handle_shelf = '0;
  logic [5:0]        in_handle_chunk = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [1:0]        out_grant_shelf;
  logic [5:0]        out_grant_chunk;
  logic [CNT_W-1:0]  out_chunks_left;
  logic [CNT_W-1:0]  out_peak_in_use;
  logic [CTR_W-1:0]  out_alloc_total;
  logic [CTR_W-1:0]  out_free_total;
  logic [CTR_W-1:0]  out_fail_total;
  logic [REQ_W-1:0]  out_largest_request;
  logic              out_counts_mismatch;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  result_t out_word;

  pool_scoreboard sb;

  // handles granted and not yet handed back, packed as {class, chunk}
  logic [7:0] held_chunks [$];

  int idle_max   = 0;         // longest gap between sender bursts, 0 for none
  int burst_left = 0;         // words left in the current sender burst
  int stall_mode = STALL_LIGHT;
  int stall_step = 0;
  logic [31:0] stall_bits = '0;
  int cycle_count = 0;
  int words_sent  = 0;
  int reg_writes  = 0;

  size_class_pool_allocator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_request_size     (in_request_size),
    .in_handle_shelf     (in_handle_shelf),
    .in_handle_chunk     (in_handle_chunk),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_grant_shelf     (out_grant_shelf),
    .out_grant_chunk     (out_grant_chunk),
    .out_chunks_left     (out_chunks_left),
    .out_peak_in_use     (out_peak_in_use),
    .out_alloc_total     (out_alloc_total),
    .out_free_total      (out_free_total),
    .out_fail_total      (out_fail_total),
    .out_largest_request (out_largest_request),
    .out_counts_mismatch (out_counts_mismatch),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  assign out_word = {out_status, out_grant_shelf, out_grant_chunk, out_chunks_left,
                     out_peak_in_use, out_alloc_total, out_free_total, out_fail_total,
                     out_largest_request, out_counts_mismatch};

  always #(CLK_HALF) clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("no progress, run stopped after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: a fresh random stall word once its bits are used up, two bits per cycle
  always @(posedge clk) begin
    if (stall_step == 0) stall_bits = $urandom;
    case (stall_mode)
      STALL_NONE:  out_ready <= 1'b1;
      STALL_LIGHT: out_ready <= stall_bits[2*stall_step] | stall_bits[2*stall_step+1];
      default:     out_ready <= stall_bits[2*stall_step] & stall_bits[2*stall_step+1];
    endcase
    stall_step = (stall_step + 1) % 16;
  end

  // result monitor: every taken result word is checked against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_word);
  end

  // one input word; the sender pauses between bursts of random length
  task automatic push_word(input logic [1:0] f, input logic [REQ_W-1:0] req,
                           input logic [1:0] hs, input logic [5:0] hc);
    result_t want;
    if (idle_max != 0 && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, idle_max)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    in_valid        <= 1'b1;
    in_func         <= f;
    in_request_size <= req;
    in_handle_shelf <= hs;
    in_handle_chunk <= hc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = sb.note_word(f, req, hs, hc);
    words_sent++;
    // remember grants so that later frees hand back real chunks
    if (f == FUNC_ALLOC && want.status == STAT_OK)
      held_chunks.push_back({want.grant_shelf, want.grant_chunk});
  endtask

  // stop sending and let every owed result come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_reg(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // random words with a given mix; storm piles noise frees onto classes 0 and 1
  task automatic run_mix(input int n, input int alloc_pct, input int free_pct,
                         input bit storm);
    int r, k, v, j;
    logic [1:0] f, hs;
    logic [5:0] hc;
    logic [7:0] h;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(0, 99);
      v  = $urandom_range(0, 65535);
      hs = 2'($urandom_range(0, 3));
      hc = 6'($urandom_range(0, 63));
      if (r < alloc_pct) begin
        f = FUNC_ALLOC;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // just below, at or just above one class size
            k = $urandom_range(0, NSH - 1);
            v = sb.shelf_size[k];
            v = v - 1 + $urandom_range(0, 2);
            if (v > 65535) v = 65535;
          end
          5, 6, 7: v = $urandom_range(0, 2000);
          8:       v = $urandom_range(0, 64);
          default: ;
        endcase
      end else if (r < alloc_pct + free_pct) begin
        f = FUNC_FREE;
        if (!storm && held_chunks.size() != 0 && $urandom_range(0, 99) < 85) begin
          j = $urandom_range(0, held_chunks.size() - 1);
          h = held_chunks[j];
          held_chunks.delete(j);
          hs = h[7:6];
          hc = h[5:0];
        end else if (storm) begin
          hs = 2'($urandom_range(0, 1));
        end
      end else begin
        f = FUNC_QUERY;
      end
      push_word(f, REQ_W'(v), hs, hc);
    end
  endtask

  initial begin
    int n, alloc_pct, free_pct;
    bit storm;
    int leftover;
    logic [REQ_W-1:0] sz [NSH];
    logic [CNT_W-1:0] cnt [NSH];

    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, reset sizes 16/64/256/1024 and 64 chunks each ----
    idle_max = 0;
    push_word(FUNC_QUERY, '0, 2'd0, '0);        // untouched class
    push_word(FUNC_ALLOC, 16'd0, 2'd3, 6'd63);  // zero request, first chunk of class 0
    push_word(FUNC_ALLOC, 16'd16, '0, '0);      // exact fit of class 0
    push_word(FUNC_ALLOC, 16'd17, '0, '0);      // one over, moves to class 1
    push_word(FUNC_ALLOC, 16'd1024, '0, '0);    // top class, exact
    push_word(FUNC_ALLOC, 16'd1025, '0, '0);    // nothing fits
    push_word(FUNC_FREE, 16'hFFFF, 2'd0, 6'd0);
    push_word(FUNC_FREE, '0, 2'd0, 6'd63);      // never granted, pushed anyway
    push_word(FUNC_ALLOC, 16'd1, '0, '0);       // lifo: comes back as chunk 63
    push_word(FUNC_FREE, '0, 2'd3, 6'd63);
    push_word(FUNC_QUERY, '0, 2'd0, '0);
    push_word(FUNC_QUERY, '0, 2'd1, '0);
    push_word(FUNC_QUERY, '0, 2'd3, '0);
    // class 2 with no chunks: exhausted allocate and an out of range free
    write_reg(REG_COUNT_FIRST + 3'd2, '0);
    push_word(FUNC_ALLOC, 16'd200, '0, '0);
    push_word(FUNC_FREE, '0, 2'd2, 6'd0);
    push_word(FUNC_QUERY, '0, 2'd2, '0);
    // class 0 larger than the others: first fit by index still picks it
    write_reg(REG_SIZE_FIRST, 16'hFFFF);
    push_word(FUNC_ALLOC, 16'hFFFF, '0, '0);
    push_word(FUNC_ALLOC, 16'd5, '0, '0);
    push_word(FUNC_QUERY, '0, 2'd0, '0);

    // ---- random phases, each under its own register setting ----
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // default: random strictly ascending sizes and random counts
      sz[0] = $urandom_range(1, 300);
      sz[1] = sz[0] + $urandom_range(1, 2000);
      sz[2] = sz[1] + $urandom_range(1, 8000);
      sz[3] = sz[2] + $urandom_range(1, 65535 - sz[2]);
      for (int k = 0; k < NSH; k++) cnt[k] = CNT_W'($urandom_range(0, 64));
      n = 220;
      alloc_pct = 45;
      free_pct  = 35;
      storm = 1'b0;
      idle_max = 3;
      stall_mode = STALL_LIGHT;
      case (ph)
        0: begin
          // reset-like sizes with full classes
          for (int k = 0; k < NSH; k++) begin
            sz[k]  = REQ_W'(RST_SIZE_BASE << (2 * k));
            cnt[k] = RST_COUNT;
          end
          n = 260;
        end
        1: begin
          // smallest sizes and tiny classes, exhaustion is common
          sz  = '{16'd1, 16'd2, 16'd3, 16'hFFFF};
          cnt = '{7'd1, 7'd0, 7'd2, 7'd64};
          alloc_pct = 50;
          idle_max = 2;
          stall_mode = STALL_HEAVY;
        end
        2: begin
          idle_max = 6;
          n = 260;
        end
        3: begin
          // sizes out of order
          sz[0] = $urandom_range(2000, 65535);
          sz[1] = $urandom_range(1, 1999);
          sz[2] = $urandom_range(1, 65535);
          sz[3] = $urandom_range(1, 1000);
          idle_max = 2;
          stall_mode = STALL_NONE;
        end
        4: begin
          // free storm: repeated frees drive the free count to saturation
          for (int k = 0; k < NSH; k++) cnt[k] = RST_COUNT;
          alloc_pct = 10;
          free_pct = 75;
          storm = 1'b1;
          idle_max = 0;
          stall_mode = STALL_NONE;
          n = 300;
        end
        5: begin
          // back to back with small classes
          for (int k = 0; k < NSH; k++) cnt[k] = CNT_W'($urandom_range(1, 8));
          alloc_pct = 50;
          free_pct = 30;
          idle_max = 0;
          stall_mode = STALL_NONE;
        end
        6: begin
          // allocate heavy on full classes, top class takes anything
          sz[3] = 16'hFFFF;
          for (int k = 0; k < NSH; k++) cnt[k] = RST_COUNT;
          alloc_pct = 70;
          free_pct = 20;
          idle_max = 1;
          stall_mode = STALL_HEAVY;
        end
        default: begin
          cnt[1] = '0;
          cnt[3] = 7'd1;
          alloc_pct = 40;
          free_pct = 40;
          idle_max = 4;
          n = 200;
        end
      endcase
      for (int k = 0; k < NSH; k++) write_reg(REG_SIZE_FIRST + CFG_AW'(k), sz[k]);
      for (int k = 0; k < NSH; k++)
        write_reg(REG_COUNT_FIRST + CFG_AW'(k), CFG_DW'(cnt[k]));
      held_chunks.delete();
      burst_left = 0;
      run_mix(n, alloc_pct, free_pct, storm);
    end

    // ---- wind down and report ----
    settle();
    repeat (8) @(posedge clk);
    leftover = sb.owed_results.size();
    if (leftover != 0) $display("%0d expected result words never arrived", leftover);
    $display("sent %0d words and %0d register writes; %0d grants, %0d no-fit, %0d exhausted",
             words_sent, reg_writes, sb.grants, sb.nofits, sb.exhausted);
    $display("%0d frees taken, %0d queries, %0d result words compared, %0d mismatches",
             sb.frees_taken, sb.queries, sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### size_class_pool_allocator.f
hdl/scpa_pkg.sv
hdl/scpa_ram.sv
hdl/scpa_regs.sv
hdl/size_class_pool_allocator.sv
hdl/scpa_checker.sv
tb/size_class_pool_allocator_tb.sv
